>>> rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg: shared types and codes of the fixed-partition fit allocator
// Request kinds, result status codes, fit modes, the sequencer state type and
// the command bundle that the control broadcasts along the row of cells.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    // Fixed field widths of the channels.
    localparam int AMOUNT_W = 16;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;

    // Request kinds.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 2'd3;

    // Fit modes; any other code selects first fit.
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Sequencer states.
    typedef enum logic
    {
        S_IDLE,
        S_SEARCH
    } state_t;

    // Command bundle broadcast to every cell.
    typedef struct packed
    {
        logic              load;
        logic              alloc;
        logic [MODE_W-1:0] mode;
    } cmd_t;

endpackage

>>> rtl/fpfa_if.sv
// ----------------------------------------------------------------------------
// fpfa_if: valid/ready channels of the allocator
// Request channel, response channel and the mode write channel.
// ----------------------------------------------------------------------------
interface fpfa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [fpfa_pkg::AMOUNT_W-1:0] amount;

    modport source (output valid, output req_type, output amount, input ready);
    modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface fpfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fpfa_pkg::STATUS_W-1:0] status;
    logic [fpfa_pkg::INDEX_W-1:0]  block_index;
    logic [fpfa_pkg::AMOUNT_W-1:0] remaining;

    modport source (output valid, output status, output block_index,
                    output remaining, input ready);
    modport sink   (input valid, input status, input block_index,
                    input remaining, output ready);
endinterface

interface fpfa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fpfa_pkg::MODE_W-1:0] fit_mode;

    modport source (output valid, output fit_mode, input ready);
    modport sink   (input valid, input fit_mode, output ready);
endinterface

>>> rtl/fpfa_cell.sv
// ----------------------------------------------------------------------------
// fpfa_cell: one partition of the allocator table
// Holds one block size with its loaded and used flags, and folds itself into
// the best candidate that travels down the row, one cell per cycle.
// ----------------------------------------------------------------------------
module fpfa_cell #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 6,
    parameter int CELL_IDX  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpfa_pkg::cmd_t       cmd,
    input  logic [IDX_W-1:0]     cmd_idx,
    input  logic [SIZE_BITS-1:0] data,
    input  logic                 found_in,
    input  logic [IDX_W-1:0]     idx_in,
    input  logic [SIZE_BITS-1:0] size_in,
    output logic                 found_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic [SIZE_BITS-1:0] size_out
);
    import fpfa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                 loaded_reg;
    logic                 used_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] cand_size_reg;
    logic                 hit;
    logic                 fits;
    logic                 take;

    assign hit = (cmd_idx == MY_IDX);

    // This block is free and large enough for the request on the data bus.
    assign fits = loaded_reg && !used_reg && (size_reg >= data);

    // Replace the incoming candidate only on a strictly better size, so that
    // ties stay with the lower index.
    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!found_in)
            begin
                take = 1'b1;
            end
            else if (cmd.mode == FIT_BEST)
            begin
                take = (size_reg < size_in);
            end
            else if (cmd.mode == FIT_WORST)
            begin
                take = (size_reg > size_in);
            end
        end
    end

    // Table entry flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            used_reg   <= 1'b0;
        end
        else if (cmd.load && hit)
        begin
            loaded_reg <= 1'b1;
            used_reg   <= 1'b0;
        end
        else if (cmd.alloc && hit)
        begin
            used_reg <= 1'b1;
        end
    end

    // Table entry size.
    always_ff @(posedge clk)
    begin
        if (cmd.load && hit)
        begin
            size_reg <= data;
        end
        else if (cmd.alloc && hit)
        begin
            size_reg <= size_reg - data;
        end
    end

    // Candidate handed to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_in || take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg       <= MY_IDX;
            cand_size_reg <= size_reg;
        end
        else
        begin
            idx_reg       <= idx_in;
            cand_size_reg <= size_in;
        end
    end

    assign found_out = found_reg;
    assign idx_out   = idx_reg;
    assign size_out  = cand_size_reg;

endmodule

>>> rtl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator: first, best and worst fit partition allocator
// A row of partition cells with a small sequencer that loads blocks, runs a
// candidate search down the row and commits the chosen block.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                              Handshake
//  req      in         req_type, amount                     valid/ready
//  rsp      out        status, block_index, remaining       valid/ready
//  cfg      in         fit_mode                             valid/ready
//
// A load request is answered straight from the idle state. An allocate request
// lets the candidate walk the row of cells one cell per cycle, then the pick
// is committed and the response is registered.
// Reset clears the loaded and used flags, the block count and the fit mode.
// A new request is taken while idle once the response register is free or is
// being read in that cycle; a stalled response holds in its register.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    fpfa_req_if.sink   req,
    fpfa_rsp_if.source rsp,
    fpfa_cfg_if.sink   cfg
);
    import fpfa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
    localparam int XW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      step_reg;
    logic [CNT_W-1:0]      step_next;
    logic [SIZE_BITS-1:0]  amt_reg;
    logic [SIZE_BITS-1:0]  amt_next;
    logic [MODE_W-1:0]     mode_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [INDEX_W-1:0]    index_reg;
    logic [INDEX_W-1:0]    index_next;
    logic [AMOUNT_W-1:0]   remain_reg;
    logic [AMOUNT_W-1:0]   remain_next;

    logic [AW-1:0]         amt_wide;
    logic [SIZE_BITS-1:0]  amt_in;
    logic                  in_ready;
    logic                  in_take;
    logic                  table_full;
    logic                  search_done;
    logic                  out_write;
    cmd_t                  cmd;
    logic [IDX_W-1:0]      cmd_idx;
    logic [SIZE_BITS-1:0]  data;
    logic [SIZE_BITS-1:0]  rem;
    logic [AW-1:0]         rem_wide;
    logic [XW-1:0]         load_idx_wide;
    logic [XW-1:0]         pick_idx_wide;

    logic                  found_w [MAX_BLOCKS+1];
    logic [IDX_W-1:0]      idx_w   [MAX_BLOCKS+1];
    logic [SIZE_BITS-1:0]  size_w  [MAX_BLOCKS+1];

    // Request amount cut or extended to the table width.
    assign amt_wide = AW'(req.amount);
    assign amt_in   = amt_wide[SIZE_BITS-1:0];

    assign table_full  = (count_reg >= CNT_W'(MAX_BLOCKS));
    assign search_done = (step_reg == CNT_W'(MAX_BLOCKS));
    assign in_take     = req.valid && in_ready;

    assign rem           = size_w[MAX_BLOCKS] - amt_reg;
    assign rem_wide      = AW'(rem);
    assign load_idx_wide = XW'(count_reg[IDX_W-1:0]);
    assign pick_idx_wide = XW'(idx_w[MAX_BLOCKS]);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take && (req.req_type == REQ_ALLOC))
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake, cell commands and response contents.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.alloc   = 1'b0;
        cmd.mode    = mode_reg;
        cmd_idx     = count_reg[IDX_W-1:0];
        data        = amt_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        amt_next    = amt_reg;
        out_write   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        remain_next = remain_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !out_valid_reg || rsp.ready;
                data     = amt_in;
                if (in_take)
                begin
                    amt_next  = amt_in;
                    step_next = '0;
                    if (req.req_type == REQ_LOAD)
                    begin
                        out_write   = 1'b1;
                        remain_next = '0;
                        if (table_full)
                        begin
                            status_next = ST_FULL;
                            index_next  = '0;
                        end
                        else
                        begin
                            cmd.load    = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_LOADED;
                            index_next  = load_idx_wide[INDEX_W-1:0];
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                step_next = step_reg + 1'b1;
                cmd_idx   = idx_w[MAX_BLOCKS];
                if (search_done)
                begin
                    out_write = 1'b1;
                    if (found_w[MAX_BLOCKS])
                    begin
                        cmd.alloc   = 1'b1;
                        status_next = ST_ALLOC;
                        index_next  = pick_idx_wide[INDEX_W-1:0];
                        remain_next = rem_wide[AMOUNT_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_NOFIT;
                        index_next  = '0;
                        remain_next = '0;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Response valid follows writes and reads of the response register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_write)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            mode_reg      <= FIT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mode_reg <= cfg.fit_mode;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        amt_reg    <= amt_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        remain_reg <= remain_next;
    end

    // Row of partition cells; the first cell sees no candidate.
    assign found_w[0] = 1'b0;
    assign idx_w[0]   = '0;
    assign size_w[0]  = '0;

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        fpfa_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .cmd_idx   (cmd_idx),
            .data      (data),
            .found_in  (found_w[i]),
            .idx_in    (idx_w[i]),
            .size_in   (size_w[i]),
            .found_out (found_w[i+1]),
            .idx_out   (idx_w[i+1]),
            .size_out  (size_w[i+1])
        );
    end

    assign req.ready       = in_ready;
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.block_index = index_reg;
    assign rsp.remaining   = remain_reg;

endmodule
